@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package tcw_pkg;

    // Action codes carried by the action field of a command beat.
    localparam logic [1:0] ACT_PUT_CHAR  = 2'd0;
    localparam logic [1:0] ACT_DELETE    = 2'd1;
    localparam logic [1:0] ACT_POS_WRITE = 2'd2;
    localparam logic [1:0] ACT_READ      = 2'd3;

    // Register indexes of the configuration port.
    localparam logic CFG_TEXT_ATTR = 1'b0;
    localparam logic CFG_POS_LIMIT = 1'b1;

    // Character codes and the attribute that the power-up clear uses.
    localparam logic [7:0] BLANK_CHAR   = 8'd32;
    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] RESET_ATTR   = 8'd7;

    // Depth of the command queue between the front and the back end.
    localparam int FIFO_DEPTH = 2;

    // Command kinds after classification by the front end.
    typedef enum logic [2:0] {
        K_PUT_CHAR  = 3'd0,
        K_NEWLINE   = 3'd1,
        K_DELETE    = 3'd2,
        K_POS_WRITE = 3'd3,
        K_READ      = 3'd4
    } t_kind;

    // Classified command, without the cell index (its width is a parameter).
    typedef struct packed {
        t_kind      kind;
        logic       ok;
        logic [7:0] char_code;
    } t_cmd;

    // Result beat produced by the back end.
    typedef struct packed {
        logic       valid;
        logic       accepted;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } t_result;

    // Back-end sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_BLANK  = 7'b0010000,
        ST_PAD    = 7'b0100000,
        ST_RDATA  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/tcw_front.sv @@
// Front end of the text console writer: takes command beats and classifies them.
// Depends on tcw_pkg for action codes and the command type.
`default_nettype none

module tcw_front #(
    parameter int IDX_W = 11,
    parameter int CELLS = 2000
) (
    input  wire logic             i_start,
    input  wire logic             i_hold,
    input  wire logic             i_full,
    input  wire logic [1:0]       i_action,
    input  wire logic [7:0]       i_char_code,
    input  wire logic [IDX_W-1:0] i_cell_index,
    input  wire logic [IDX_W-1:0] i_pos_limit,
    output tcw_pkg::t_cmd         o_cmd,
    output logic                  o_busy,
    output logic                  o_push
);

    logic in_screen;

    // The block refuses new beats during reset, the clear pass or a full queue.
    assign o_busy = i_hold | i_full;
    assign o_push = i_start & ~o_busy;

    assign in_screen = (i_cell_index < IDX_W'(CELLS));

    // Classify the command and settle its range checks up front.
    always_comb begin
        o_cmd.char_code = i_char_code;
        o_cmd.ok        = 1'b1;
        case (i_action)
            tcw_pkg::ACT_PUT_CHAR: begin
                o_cmd.kind = (i_char_code == tcw_pkg::NEWLINE_CHAR) ?
                             tcw_pkg::K_NEWLINE : tcw_pkg::K_PUT_CHAR;
            end
            tcw_pkg::ACT_DELETE: begin
                o_cmd.kind = tcw_pkg::K_DELETE;
            end
            tcw_pkg::ACT_POS_WRITE: begin
                o_cmd.kind = tcw_pkg::K_POS_WRITE;
                o_cmd.ok   = in_screen && (i_cell_index <= i_pos_limit);
            end
            tcw_pkg::ACT_READ: begin
                o_cmd.kind = tcw_pkg::K_READ;
                o_cmd.ok   = in_screen;
            end
            default: begin
                o_cmd.kind = tcw_pkg::K_READ;
                o_cmd.ok   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcw_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on tcw_pkg for its depth.
`default_nettype none

module tcw_cmd_fifo #(
    parameter int DATA_W = 23
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_din,
    input  wire logic              i_pop,
    output logic      [DATA_W-1:0] o_dout,
    output logic                   o_full,
    output logic                   o_empty
);

    localparam int DEPTH = tcw_pkg::FIFO_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic [PTR_W-1:0]  n_wp;
    logic [PTR_W-1:0]  n_rp;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rp];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointers wrap at the queue depth.
    assign n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;

    // Pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcw_back.sv @@
// Back end of the text console writer: owns the screen memory, cursor and column,
// and sequences clear, scroll, newline padding, writes and reads. Depends on tcw_pkg.
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int IDX_W   = 11,
    parameter int COL_W   = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire tcw_pkg::t_cmd    i_cmd,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [7:0]       i_text_attr,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic      [IDX_W-1:0] o_cursor,
    output logic      [COL_W-1:0] o_column,
    output tcw_pkg::t_result      o_result
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int MOVE_N = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    // Screen memory: one write port and one registered read port.
    logic [15:0]       r_screen [CELLS];
    logic [15:0]       r_rdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [15:0]       mem_wd;
    logic [ADDR_W-1:0] mem_ra;

    tcw_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]  r_col, n_col;
    tcw_pkg::t_cmd     r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    tcw_pkg::t_result  r_res, n_res;

    logic [15:0]       blank_cell;
    logic [IDX_W-1:0]  scroll_src;
    logic [IDX_W-1:0]  cursor_dec;
    logic [IDX_W-1:0]  cnt_dec;
    logic [COL_W-1:0]  col_inc;

    assign blank_cell = {i_text_attr, tcw_pkg::BLANK_CHAR};
    assign scroll_src = r_cnt + IDX_W'(COLUMNS);
    assign cursor_dec = r_cursor - 1'b1;
    assign cnt_dec    = r_cnt - 1'b1;
    assign col_inc    = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + 1'b1;

    assign o_clearing = r_state[0];
    assign o_cursor   = r_cursor;
    assign o_column   = r_col;
    assign o_result   = r_res;

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cursor = r_cursor;
        n_col    = r_col;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_res    = '0;
        o_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = blank_cell;
        mem_ra   = '0;
        case (r_state)
            tcw_pkg::ST_CLEAR: begin
                // Power-up clear, one cell a cycle, with the reset attribute.
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                mem_wd = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
                if (r_cnt == IDX_W'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = i_idx;
                    n_state = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                n_state = tcw_pkg::ST_IDLE;
                case (r_cmd.kind)
                    tcw_pkg::K_PUT_CHAR, tcw_pkg::K_NEWLINE: begin
                        if (r_cursor >= IDX_W'(CELLS)) begin
                            n_cnt   = '0;
                            n_state = tcw_pkg::ST_SCROLL;
                        end else if (r_cmd.kind == tcw_pkg::K_NEWLINE) begin
                            n_state = tcw_pkg::ST_PAD;
                        end else begin
                            mem_we         = 1'b1;
                            mem_wa         = r_cursor[ADDR_W-1:0];
                            mem_wd         = {i_text_attr, r_cmd.char_code};
                            n_cursor       = r_cursor + 1'b1;
                            n_col          = col_inc;
                            n_res.valid    = 1'b1;
                            n_res.accepted = 1'b1;
                        end
                    end
                    tcw_pkg::K_DELETE: begin
                        n_res.valid = 1'b1;
                        if (r_cursor != '0) begin
                            mem_we         = 1'b1;
                            mem_wa         = cursor_dec[ADDR_W-1:0];
                            n_cursor       = cursor_dec;
                            n_col          = (r_col == '0) ? COL_W'(COLUMNS - 1)
                                                           : r_col - 1'b1;
                            n_res.accepted = 1'b1;
                        end
                    end
                    tcw_pkg::K_POS_WRITE: begin
                        mem_we         = r_cmd.ok;
                        mem_wa         = r_idx[ADDR_W-1:0];
                        mem_wd         = {i_text_attr, r_cmd.char_code};
                        n_res.valid    = 1'b1;
                        n_res.accepted = r_cmd.ok;
                    end
                    tcw_pkg::K_READ: begin
                        mem_ra = r_idx[ADDR_W-1:0];
                        if (r_cmd.ok) begin
                            n_state = tcw_pkg::ST_RDATA;
                        end else begin
                            n_res.valid = 1'b1;
                        end
                    end
                    default: begin
                        n_res.valid = 1'b1;
                    end
                endcase
            end
            tcw_pkg::ST_SCROLL: begin
                // Move rows up: read one row ahead, write the previous cycle's data.
                if (r_cnt < IDX_W'(MOVE_N)) begin
                    mem_ra = scroll_src[ADDR_W-1:0];
                end
                if (r_cnt != '0) begin
                    mem_we = 1'b1;
                    mem_wa = cnt_dec[ADDR_W-1:0];
                    mem_wd = r_rdata;
                end
                if (r_cnt == IDX_W'(MOVE_N)) begin
                    n_state = tcw_pkg::ST_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::ST_BLANK: begin
                // Blank the bottom row, then run the character again.
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                if (r_cnt == IDX_W'(CELLS - 1)) begin
                    n_cnt    = '0;
                    n_cursor = r_cursor - IDX_W'(COLUMNS);
                    n_state  = tcw_pkg::ST_EXEC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            tcw_pkg::ST_PAD: begin
                // Newline padding, one blank a cycle to the end of the row.
                mem_we   = (r_cursor < IDX_W'(CELLS));
                mem_wa   = r_cursor[ADDR_W-1:0];
                n_cursor = r_cursor + 1'b1;
                n_col    = col_inc;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_res.valid    = 1'b1;
                    n_res.accepted = 1'b1;
                    n_state        = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_RDATA: begin
                n_res.valid     = 1'b1;
                n_res.accepted  = 1'b1;
                n_res.read_char = r_rdata[7:0];
                n_res.read_attr = r_rdata[15:8];
                n_state         = tcw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcw_pkg::ST_CLEAR;
            r_cnt    <= '0;
            r_cursor <= '0;
            r_col    <= '0;
            r_res    <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_res    <= n_res;
        end
    end

    // Command payload.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
    end

    // Screen memory ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
        r_rdata <= r_screen[mem_ra];
    end

endmodule

`default_nettype wire

@@ rtl/text_console_writer_core.sv @@
// Top level of the text console writer: configuration registers, front end,
// command queue and back end. Depends on tcw_pkg, tcw_front, tcw_cmd_fifo, tcw_back.
//
// Usage: a command beat (action, char_code, cell_index) is taken at a rising
// edge where start is high and busy is low. Each command gives exactly one
// result beat, shown for one cycle with o_strobe high; the receiver cannot
// stall it. Results come back in command order.
// A read returns its data through the registered read port of the screen
// memory, and a newline pads the rest of the row with blanks.
// A put-char at the end of the screen first scrolls: the rows move up one
// and the bottom row is blanked.
// The back-end sequencer pops a command and then executes it before it pops
// the next; the screen memory has one write and one read port. A two-beat
// queue lets the front take commands while the back end is still working;
// busy rises when it is full. After reset busy stays high while the screen
// is cleared to spaces with attribute 7. Configuration writes through
// i_cfg_we are taken at any time, but should be made only while idle.
`default_nettype none

module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [1:0]                            i_action,
    input  wire logic [7:0]                            i_char_code,
    input  wire logic [$clog2(COLUMNS * ROWS + 1)-1:0] i_cell_index,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_index,
    input  wire logic [(($clog2(COLUMNS * ROWS + 1) > 8) ?
                        $clog2(COLUMNS * ROWS + 1) : 8)-1:0] i_cfg_data,
    output logic                                       o_strobe,
    output logic      [$clog2(COLUMNS * ROWS + 1)-1:0] o_cursor_cell,
    output logic      [$clog2(COLUMNS)-1:0]            o_column,
    output logic      [7:0]                            o_read_char,
    output logic      [7:0]                            o_read_attr,
    output logic                                       o_accepted
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int IDX_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CMD_W  = $bits(tcw_pkg::t_cmd);
    localparam int FIFO_W = CMD_W + IDX_W;

    logic [7:0]        r_text_attr;
    logic [IDX_W-1:0]  r_pos_limit;

    tcw_pkg::t_cmd     front_cmd;
    logic              push;
    logic              fifo_full;
    logic              fifo_empty;
    logic [FIFO_W-1:0] fifo_dout;
    logic              pop;
    logic              clearing;
    tcw_pkg::t_result  result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= tcw_pkg::RESET_ATTR;
            r_pos_limit <= IDX_W'(CELLS - 1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == tcw_pkg::CFG_TEXT_ATTR) begin
                r_text_attr <= i_cfg_data[7:0];
            end
            if (i_cfg_index == tcw_pkg::CFG_POS_LIMIT) begin
                r_pos_limit <= i_cfg_data[IDX_W-1:0];
            end
        end
    end

    // Command intake and classification.
    tcw_front #(
        .IDX_W (IDX_W),
        .CELLS (CELLS)
    ) u_front (
        .i_start      (start),
        .i_hold       (~i_rst_n | clearing),
        .i_full       (fifo_full),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_pos_limit  (r_pos_limit),
        .o_cmd        (front_cmd),
        .o_busy       (busy),
        .o_push       (push)
    );

    // Queue between the two halves.
    tcw_cmd_fifo #(
        .DATA_W (FIFO_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   ({front_cmd, i_cell_index}),
        .i_pop   (pop),
        .o_dout  (fifo_dout),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // Execution against the screen memory.
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .IDX_W   (IDX_W),
        .COL_W   (COL_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (fifo_empty),
        .i_cmd       (tcw_pkg::t_cmd'(fifo_dout[FIFO_W-1:IDX_W])),
        .i_idx       (fifo_dout[IDX_W-1:0]),
        .i_text_attr (r_text_attr),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_cursor    (o_cursor_cell),
        .o_column    (o_column),
        .o_result    (result)
    );

    assign o_strobe    = result.valid;
    assign o_accepted  = result.accepted;
    assign o_read_char = result.read_char;
    assign o_read_attr = result.read_attr;

    // A reset starts the clear pass, so busy is high right after it.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy not raised after reset");

    // The sequencer returns to idle after every result, so strobes never abut.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result beats in consecutive cycles");

    // The cursor never passes the one-past-end cell.
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cursor_cell <= IDX_W'(CELLS)))
        else $error("cursor beyond the end of the screen");

endmodule

`default_nettype wire

@@ tb/text_console_writer_core_tb.sv @@
// Self-checking testbench for text_console_writer_core: command beats are driven through the
// start/busy handshake and each result beat is compared with a cycle-free screen model.
// Depends on tcw_pkg and the RTL under rtl/; no files or arguments are read.
`default_nettype none

module text_console_writer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
    localparam int IDX_W       = 11;
    localparam int COL_W       = 7;
    localparam int CLK_PERIOD  = 20;
    localparam int RUN_LIMIT   = 10_000_000;
    localparam int TAIL_CYCLES = 200;

    // One result beat as the screen model sees it.
    typedef struct packed {
        logic [IDX_W-1:0] cursor;
        logic [COL_W-1:0] column;
        logic [7:0]       rchar;
        logic [7:0]       rattr;
        logic             accepted;
    } console_view_t;

    // One row of the directed table: either a register write or a command beat.
    typedef struct packed {
        logic             is_reg;
        logic             reg_idx;
        logic [IDX_W-1:0] reg_val;
        logic [1:0]       act;
        logic [7:0]       ch;
        logic [IDX_W-1:0] idx;
        logic             typed;
        console_view_t    want;
    } stim_row_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_action;
    logic [7:0]       i_char_code;
    logic [IDX_W-1:0] i_cell_index;
    logic             i_cfg_we;
    logic             i_cfg_index;
    logic [IDX_W-1:0] i_cfg_data;
    logic             o_strobe;
    logic [IDX_W-1:0] o_cursor_cell;
    logic [COL_W-1:0] o_column;
    logic [7:0]       o_read_char;
    logic [7:0]       o_read_attr;
    logic             o_accepted;

    // Screen model state and its copy of the registers.
    logic [15:0]      screen_img [CELLS];
    int unsigned      cur_pos;
    int unsigned      col_pos;
    logic [7:0]       attr_reg;
    logic [IDX_W-1:0] limit_reg;

    console_view_t    pending_views [$];
    stim_row_t        directed_rows [$];
    int unsigned      idle_pct;
    int unsigned      item_count;
    int unsigned      result_count;
    int unsigned      rejected_count;
    int unsigned      scroll_count;
    int unsigned      fail_count;
    int unsigned      cycle_count;

    text_console_writer_core #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_strobe     (o_strobe),
        .o_cursor_cell(o_cursor_cell),
        .o_column     (o_column),
        .o_read_char  (o_read_char),
        .o_read_attr  (o_read_attr),
        .o_accepted   (o_accepted)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("[text_console_writer_core] ERROR");
            $finish;
        end
    end

    function automatic console_view_t view_of(input int unsigned cur, input int unsigned col,
                                              input int unsigned rch, input int unsigned rat,
                                              input int unsigned acc);
        console_view_t v;
        v.cursor   = cur[IDX_W-1:0];
        v.column   = col[COL_W-1:0];
        v.rchar    = rch[7:0];
        v.rattr    = rat[7:0];
        v.accepted = acc[0];
        return v;
    endfunction

    function automatic stim_row_t cmd_row(input logic [1:0] act, input int unsigned ch,
                                          input int unsigned idx, input int unsigned typed,
                                          input console_view_t want);
        stim_row_t r;
        r        = '0;
        r.act    = act;
        r.ch     = ch[7:0];
        r.idx    = idx[IDX_W-1:0];
        r.typed  = typed[0];
        r.want   = want;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic ridx, input int unsigned val);
        stim_row_t r;
        r         = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = ridx;
        r.reg_val = val[IDX_W-1:0];
        return r;
    endfunction

    // Stores go nowhere past the last cell.
    function automatic void store_cell(input int unsigned where, input logic [7:0] ch);
        if (where < CELLS)
            screen_img[where] = {attr_reg, ch};
    endfunction

    // Screen model: applies one command and returns the result beat it gives.
    function automatic console_view_t next_console_view(input logic [1:0] act,
                                                        input logic [7:0] ch,
                                                        input logic [IDX_W-1:0] idx);
        console_view_t v;
        int unsigned   j;
        v = '0;
        case (act)
            tcw_pkg::ACT_PUT_CHAR: begin
                // Past the last cell: move rows up one and blank the bottom row.
                if (cur_pos >= CELLS) begin
                    for (j = 0; j < CELLS - SCREEN_COLS; j++)
                        screen_img[j] = screen_img[j + SCREEN_COLS];
                    for (j = CELLS - SCREEN_COLS; j < CELLS; j++)
                        screen_img[j] = {attr_reg, tcw_pkg::BLANK_CHAR};
                    cur_pos -= SCREEN_COLS;
                    scroll_count++;
                end
                if (ch == tcw_pkg::NEWLINE_CHAR) begin
                    for (j = col_pos; j < SCREEN_COLS; j++) begin
                        store_cell(cur_pos, tcw_pkg::BLANK_CHAR);
                        cur_pos++;
                    end
                    col_pos = 0;
                end else begin
                    store_cell(cur_pos, ch);
                    cur_pos++;
                    col_pos = (col_pos + 1 >= SCREEN_COLS) ? 0 : col_pos + 1;
                end
                v.accepted = 1'b1;
            end
            tcw_pkg::ACT_DELETE: begin
                if (cur_pos != 0) begin
                    cur_pos--;
                    col_pos = (col_pos == 0) ? SCREEN_COLS - 1 : col_pos - 1;
                    store_cell(cur_pos, tcw_pkg::BLANK_CHAR);
                    v.accepted = 1'b1;
                end
            end
            tcw_pkg::ACT_POS_WRITE: begin
                // The byte goes in raw; a newline code is just a character here.
                if (idx <= limit_reg && idx < CELLS) begin
                    store_cell(idx, ch);
                    v.accepted = 1'b1;
                end
            end
            default: begin
                if (idx < CELLS) begin
                    v.rchar    = screen_img[idx][7:0];
                    v.rattr    = screen_img[idx][15:8];
                    v.accepted = 1'b1;
                end
            end
        endcase
        v.cursor = cur_pos[IDX_W-1:0];
        v.column = col_pos[COL_W-1:0];
        return v;
    endfunction

    // Drive one command beat, holding it until the block takes it.
    task automatic issue(input logic [1:0] act, input logic [7:0] ch,
                         input logic [IDX_W-1:0] idx, input logic typed,
                         input console_view_t typed_view);
        console_view_t model_view;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_action     <= act;
        i_char_code  <= ch;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        model_view = next_console_view(act, ch, idx);
        pending_views.push_back(typed ? typed_view : model_view);
        item_count++;
    endtask

    // Stop sending and wait until every expected result beat has come back.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic ridx, input logic [IDX_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ridx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (ridx == tcw_pkg::CFG_TEXT_ATTR)
            attr_reg = val[7:0];
        else
            limit_reg = val;
    endtask

    // Random traffic: half of it text with frequent newlines so the screen fills and scrolls.
    task automatic run_phase(input int unsigned n_items, input int unsigned idle);
        int unsigned      pick;
        int unsigned      back;
        logic [1:0]       act;
        logic [7:0]       ch;
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 149) == 0)
                settle();
            // Every hundred beats starts with a stretch sent back to back.
            idle_pct = ((k % 100) < 25) ? 0 : idle;
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom_range(0, 255));
            idx  = IDX_W'($urandom_range(0, CELLS - 1));
            if (pick < 50) begin
                act = tcw_pkg::ACT_PUT_CHAR;
                if ($urandom_range(0, 3) == 0)
                    ch = tcw_pkg::NEWLINE_CHAR;
            end else if (pick < 62) begin
                act = tcw_pkg::ACT_DELETE;
            end else if (pick < 80) begin
                act = tcw_pkg::ACT_POS_WRITE;
                if ($urandom_range(0, 31) == 0)
                    idx = IDX_W'($urandom_range(CELLS, 2047));
            end else begin
                act  = tcw_pkg::ACT_READ;
                back = $urandom_range(1, 2 * SCREEN_COLS);
                if ($urandom_range(0, 31) == 0)
                    idx = IDX_W'($urandom_range(CELLS, 2047));
                else if ($urandom_range(0, 1) == 1 && cur_pos > back)
                    idx = IDX_W'(cur_pos - back);
            end
            issue(act, ch, idx, 1'b0, '0);
        end
    endtask

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin : result_check
        console_view_t want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_views.size() == 0) begin
                $error("result beat with no command outstanding");
                fail_count++;
            end else begin
                want = pending_views.pop_front();
                result_count++;
                if (!want.accepted)
                    rejected_count++;
                if (o_cursor_cell !== want.cursor) begin
                    $error("cursor_cell: expected %0d, got %0d", want.cursor, o_cursor_cell);
                    fail_count++;
                end
                if (o_column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, o_column);
                    fail_count++;
                end
                if (o_read_char !== want.rchar) begin
                    $error("read_char: expected %0d, got %0d", want.rchar, o_read_char);
                    fail_count++;
                end
                if (o_read_attr !== want.rattr) begin
                    $error("read_attr: expected %0d, got %0d", want.rattr, o_read_attr);
                    fail_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_action       = tcw_pkg::ACT_PUT_CHAR;
        i_char_code    = '0;
        i_cell_index   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = tcw_pkg::CFG_TEXT_ATTR;
        i_cfg_data     = '0;
        cycle_count    = 0;
        item_count     = 0;
        result_count   = 0;
        rejected_count = 0;
        scroll_count   = 0;
        fail_count     = 0;
        idle_pct       = 0;
        cur_pos        = 0;
        col_pos        = 0;
        attr_reg       = tcw_pkg::RESET_ATTR;
        limit_reg      = IDX_W'(CELLS - 1);
        for (int c = 0; c < CELLS; c++)
            screen_img[c] = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};

        // Directed table: reset contents, range edges, delete at cell zero,
        // column wrap, raw newline byte, limit rejection and a full-row newline.
        directed_rows = '{
            cmd_row(tcw_pkg::ACT_READ,      0,    0,    1, view_of(0, 0, 32, 7, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    1999, 1, view_of(0, 0, 32, 7, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    2000, 1, view_of(0, 0, 0, 0, 0)),
            cmd_row(tcw_pkg::ACT_READ,      0,    2047, 1, view_of(0, 0, 0, 0, 0)),
            cmd_row(tcw_pkg::ACT_DELETE,    0,    0,    1, view_of(0, 0, 0, 0, 0)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  65,   0,    1, view_of(1, 1, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  0,    0,    1, view_of(2, 2, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  255,  0,    1, view_of(3, 3, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    2,    1, view_of(3, 3, 255, 7, 1)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  10,   0,    1, view_of(80, 0, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_DELETE,    0,    0,    1, view_of(79, 79, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    79,   1, view_of(79, 79, 32, 7, 1)),
            reg_row(tcw_pkg::CFG_TEXT_ATTR, 255),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  120,  2047, 1, view_of(80, 0, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    79,   1, view_of(80, 0, 120, 255, 1)),
            cmd_row(tcw_pkg::ACT_POS_WRITE, 33,   2047, 1, view_of(80, 0, 0, 0, 0)),
            cmd_row(tcw_pkg::ACT_POS_WRITE, 33,   2000, 1, view_of(80, 0, 0, 0, 0)),
            reg_row(tcw_pkg::CFG_POS_LIMIT, 0),
            cmd_row(tcw_pkg::ACT_POS_WRITE, 66,   1,    1, view_of(80, 0, 0, 0, 0)),
            cmd_row(tcw_pkg::ACT_POS_WRITE, 10,   0,    1, view_of(80, 0, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    0,    1, view_of(80, 0, 10, 255, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    1,    1, view_of(80, 0, 0, 7, 1)),
            reg_row(tcw_pkg::CFG_POS_LIMIT, 1999),
            reg_row(tcw_pkg::CFG_TEXT_ATTR, 0),
            cmd_row(tcw_pkg::ACT_POS_WRITE, 170,  1999, 1, view_of(80, 0, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_READ,      0,    1999, 1, view_of(80, 0, 170, 0, 1)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  10,   1024, 1, view_of(160, 0, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_DELETE,    0,    0,    1, view_of(159, 79, 0, 0, 1)),
            cmd_row(tcw_pkg::ACT_PUT_CHAR,  127,  0,    0, '0),
            cmd_row(tcw_pkg::ACT_READ,      0,    159,  0, '0)
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The block clears the screen after reset and holds busy meanwhile.
        do
            @(posedge i_clk);
        while (busy !== 1'b0);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_reg) begin
                settle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
            end else begin
                issue(directed_rows[r].act, directed_rows[r].ch, directed_rows[r].idx,
                      directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random phases, each under its own register settings and sender gaps.
        settle();
        write_reg(tcw_pkg::CFG_TEXT_ATTR, 11'h01E);
        write_reg(tcw_pkg::CFG_POS_LIMIT, IDX_W'(CELLS - 1));
        run_phase(420, 32);

        settle();
        write_reg(tcw_pkg::CFG_TEXT_ATTR, 11'h000);
        write_reg(tcw_pkg::CFG_POS_LIMIT, 11'd1000);
        run_phase(300, 84);

        settle();
        write_reg(tcw_pkg::CFG_TEXT_ATTR, 11'h0FF);
        write_reg(tcw_pkg::CFG_POS_LIMIT, IDX_W'(CELLS - 1));
        run_phase(430, 0);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats and checked %0d result beats (%0d rejected).",
                 item_count, result_count, rejected_count);
        $display("The screen scrolled %0d times under three attribute and limit settings.",
                 scroll_count);
        if (fail_count == 0 && pending_views.size() == 0) begin
            $display("[text_console_writer_core] OK");
        end else begin
            $display("[text_console_writer_core] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
